// File: design/zsp_pkg.sv
package zsp_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 8;
  localparam int FILT_W      = SAMPLE_W + FRAC_W;
  localparam int THR_W       = 8;
  localparam int INF_W       = 9;
  localparam int LAG_DEFAULT = 10;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [THR_W-1:0] THR_RESET = 8'd40;
  localparam logic [INF_W-1:0] INF_RESET = 9'd205;
  localparam logic [INF_W-1:0] INF_ONE   = 9'd256;

  // register select, taken from paddr[2]
  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_INFLUENCE = 1'b1
  } reg_sel_t;

  typedef logic signed [1:0] sig_t;
  localparam sig_t SIG_NONE = 2'sb00;
  localparam sig_t SIG_POS  = 2'sb01;
  localparam sig_t SIG_NEG  = 2'sb11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REDUCE,
    ST_PART,
    ST_SUM,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

// File: design/zsp_zcompare.sv
// Squared z-score test:
//   256*(L-1)*d^2 > T^2*L*(L*Q - S^2)
// Free-running five-stage pipeline; inputs are held for the whole item.
module zsp_zcompare #(
  parameter int LAG = zsp_pkg::LAG_DEFAULT
) (
  input  logic                                             clk,
  input  logic [zsp_pkg::FILT_W+$clog2(LAG):0]             d_abs,
  input  logic [zsp_pkg::FILT_W+$clog2(LAG)-1:0]           s_abs,
  input  logic [2*zsp_pkg::FILT_W-2+$clog2(LAG):0]         sum_sq,
  input  logic [zsp_pkg::THR_W-1:0]                        threshold,
  output logic                                             flag
);

  localparam int LAG_W = $clog2(LAG);
  localparam int SUM_W = zsp_pkg::FILT_W + LAG_W;
  localparam int D_W   = SUM_W + 1;
  localparam int V_W   = 2 * SUM_W;
  localparam int TT_W  = 2 * zsp_pkg::THR_W;
  localparam int K_W   = TT_W + $clog2(LAG + 1);
  localparam int VH    = (V_W + 1) / 2;
  localparam int VL_W  = V_W - VH;
  localparam int CMP_W = V_W + K_W;

  logic [2*D_W-1:0]  dd;
  logic [V_W-1:0]    ss;
  logic [V_W-1:0]    lq;
  logic [TT_W-1:0]   tt;
  logic [V_W-1:0]    v;
  logic [K_W-1:0]    k;
  logic [CMP_W-1:0]  lhs1;
  logic [CMP_W-1:0]  lhs2;
  logic [CMP_W-1:0]  lhs3;
  logic [VH+K_W-1:0] p_lo;
  logic [VL_W+K_W-1:0] p_hi;
  logic [CMP_W-1:0]  rhs;

  always_ff @(posedge clk) begin
    // stage 1: squares
    dd <= (2*D_W)'(d_abs) * (2*D_W)'(d_abs);
    ss <= V_W'(s_abs) * V_W'(s_abs);
    lq <= V_W'(sum_sq) * V_W'(LAG);
    tt <= TT_W'(threshold) * TT_W'(threshold);
    // stage 2: variance term, scaled distance
    v    <= (lq > ss) ? lq - ss : '0;
    k    <= K_W'(tt) * K_W'(LAG);
    lhs1 <= (CMP_W'(dd) * CMP_W'(LAG - 1)) << zsp_pkg::FRAC_W;
    // stage 3: split v*k into two narrow products
    p_lo <= (VH+K_W)'(v[VH-1:0]) * (VH+K_W)'(k);
    p_hi <= (VL_W+K_W)'(v[V_W-1:VH]) * (VL_W+K_W)'(k);
    lhs2 <= lhs1;
    // stage 4
    rhs  <= (CMP_W'(p_hi) << VH) + CMP_W'(p_lo);
    lhs3 <= lhs2;
    // stage 5
    flag <= lhs3 > rhs;
  end

endmodule

// File: design/zscore_peak_detector.sv
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  sample (s16)
// output   out        out_valid / out_stall peak_signal (s2), warmed_up (u1)
// config   in         APB write/read       threshold_q4_4 @0x0, influence_q1_8 @0x4
//
// From accept to result load: ring read at the accept edge, the z-score
// multiply/compare pipeline (MUL, REDUCE, PART, SUM, CMP), one write-back;
// the next item is accepted only in IDLE after write-back, so items never overlap.
// The result register holds while out_stall is high; a following item still
// runs, and waits in its last cycle until the register frees.
// Synchronous reset clears sums, counters and config; the ring needs no clear.
module zscore_peak_detector #(
  parameter int LAG = zsp_pkg::LAG_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [zsp_pkg::SAMPLE_W-1:0] sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [1:0]                 peak_signal,
  output logic                              warmed_up,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [zsp_pkg::APB_AW-1:0]        paddr,
  input  logic [zsp_pkg::APB_DW-1:0]        pwdata,
  output logic [zsp_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  localparam int LAG_W = $clog2(LAG);
  localparam int CNT_W = $clog2(LAG + 1);
  localparam int F_W   = zsp_pkg::FILT_W;
  localparam int SUM_W = F_W + LAG_W;
  localparam int D_W   = SUM_W + 1;
  localparam int SQF_W = 2 * F_W - 1;
  localparam int SQ_W  = SQF_W + LAG_W;
  localparam int X_W   = zsp_pkg::SAMPLE_W;
  localparam int XSQ_W = 2 * X_W - 1;
  localparam int BL_W  = F_W + zsp_pkg::INF_W + 2;
  localparam logic signed [BL_W-1:0] BL_HALF = BL_W'(1 << (zsp_pkg::FRAC_W - 1));
  localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(LAG);
  localparam logic [LAG_W-1:0] SLOT_LAST = LAG_W'(LAG - 1);

  // config
  logic [zsp_pkg::THR_W-1:0] threshold;
  logic [zsp_pkg::INF_W-1:0] influence;

  // control
  zsp_pkg::state_t state, state_next;
  logic            accept, commit;
  logic [LAG_W-1:0] write_slot;
  logic [CNT_W-1:0] fill_count;

  // window state
  logic signed [SUM_W-1:0] window_sum, window_sum_next;
  logic [SQ_W-1:0]         window_sum_sq, window_sum_sq_next;
  logic signed [F_W-1:0]   last_filtered;
  logic [F_W-1:0]          ring [LAG];
  logic signed [F_W-1:0]   ring_rdata;

  // per-item datapath
  logic signed [X_W-1:0]   x_reg;
  logic [D_W-1:0]          d_reg;
  logic                    above_reg;
  logic [SUM_W-1:0]        sabs_reg;
  logic signed [D_W-1:0]   lx, diff;
  logic signed [F_W-1:0]   xq;
  logic [X_W-1:0]          xa;
  logic [2*X_W-1:0]        xprod;
  logic [XSQ_W-1:0]        x_sq;
  logic [F_W-1:0]          oa;
  logic [2*F_W-1:0]        oprod;
  logic [SQF_W-1:0]        old_sq;
  logic [zsp_pkg::INF_W-1:0] w_sat;
  logic signed [zsp_pkg::INF_W:0] w_s, w_c;
  logic signed [BL_W-1:0]  blend_acc;
  logic signed [F_W-1:0]   blend;
  logic [F_W-1:0]          ba;
  logic [2*F_W-1:0]        bprod;
  logic [SQF_W-1:0]        blend_sq;
  logic                    flag;
  logic                    warm, take;
  logic signed [F_W-1:0]   f_val;
  logic [SQF_W-1:0]        f_sq;

  assign pready = 1'b1;
  assign accept = in_valid && !in_stall;
  assign warm   = fill_count == FILL_FULL;

  // ---------------- config port ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= zsp_pkg::THR_RESET;
      influence <= zsp_pkg::INF_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (zsp_pkg::reg_sel_t'(paddr[2]))
        zsp_pkg::REG_THRESHOLD: threshold <= pwdata[zsp_pkg::THR_W-1:0];
        zsp_pkg::REG_INFLUENCE: influence <= pwdata[zsp_pkg::INF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (zsp_pkg::reg_sel_t'(paddr[2]))
      zsp_pkg::REG_THRESHOLD: prdata = zsp_pkg::APB_DW'(threshold);
      zsp_pkg::REG_INFLUENCE: prdata = zsp_pkg::APB_DW'(influence);
      default:                prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= zsp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    commit     = 1'b0;
    case (state)
      zsp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = zsp_pkg::ST_MUL;
      end
      zsp_pkg::ST_MUL:    state_next = zsp_pkg::ST_REDUCE;
      zsp_pkg::ST_REDUCE: state_next = zsp_pkg::ST_PART;
      zsp_pkg::ST_PART:   state_next = zsp_pkg::ST_SUM;
      zsp_pkg::ST_SUM:    state_next = zsp_pkg::ST_CMP;
      zsp_pkg::ST_CMP:    state_next = zsp_pkg::ST_DONE;
      zsp_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = zsp_pkg::ST_IDLE;
        end
      end
      default: state_next = zsp_pkg::ST_IDLE;
    endcase
  end

  // ---------------- accept: distance from mean ----------------
  assign lx   = D_W'($signed({sample, {zsp_pkg::FRAC_W{1'b0}}})) * $signed(D_W'(LAG));
  assign diff = lx - D_W'(window_sum);

  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg     <= sample;
      d_reg     <= diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
      above_reg <= !diff[D_W-1] && (diff != '0);
      sabs_reg  <= window_sum[SUM_W-1] ? SUM_W'(-window_sum) : SUM_W'(window_sum);
    end
  end

  // ---------------- history ring ----------------
  always_ff @(posedge clk) begin
    if (accept) ring_rdata <= ring[write_slot];
    if (commit) ring[write_slot] <= f_val;
  end

  // side products, registered once the sample and ring word are held
  assign xq    = $signed({x_reg, {zsp_pkg::FRAC_W{1'b0}}});
  assign xa    = x_reg[X_W-1] ? X_W'(-x_reg) : X_W'(x_reg);
  assign xprod = (2*X_W)'(xa) * (2*X_W)'(xa);
  assign oa    = ring_rdata[F_W-1] ? F_W'(-ring_rdata) : F_W'(ring_rdata);
  assign oprod = (2*F_W)'(oa) * (2*F_W)'(oa);

  // influence above one saturates
  assign w_sat = (influence > zsp_pkg::INF_ONE) ? zsp_pkg::INF_ONE : influence;
  assign w_s   = $signed({1'b0, w_sat});
  assign w_c   = $signed({1'b0, zsp_pkg::INF_ONE - w_sat});
  assign blend_acc = BL_W'(w_s) * BL_W'(xq) + BL_W'(w_c) * BL_W'(last_filtered) + BL_HALF;

  assign ba    = blend[F_W-1] ? F_W'(-blend) : F_W'(blend);
  assign bprod = (2*F_W)'(ba) * (2*F_W)'(ba);

  always_ff @(posedge clk) begin
    x_sq     <= xprod[XSQ_W-1:0];
    old_sq   <= oprod[SQF_W-1:0];
    // round to nearest on division by 256: BL_HALF is added, then the fraction bits are dropped
    blend    <= blend_acc[zsp_pkg::FRAC_W +: F_W];
    blend_sq <= bprod[SQF_W-1:0];
  end

  zsp_zcompare #(
    .LAG (LAG)
  ) u_zcompare (
    .clk       (clk),
    .d_abs     (d_reg),
    .s_abs     (sabs_reg),
    .sum_sq    (window_sum_sq),
    .threshold (threshold),
    .flag      (flag)
  );

  // ---------------- write-back ----------------
  assign take  = warm && flag;
  assign f_val = take ? blend : xq;
  assign f_sq  = take ? blend_sq : {x_sq, {(2*zsp_pkg::FRAC_W){1'b0}}};

  always_comb begin
    window_sum_next    = window_sum + SUM_W'(f_val);
    window_sum_sq_next = window_sum_sq + SQ_W'(f_sq);
    if (warm) begin
      window_sum_next    = window_sum_next - SUM_W'(ring_rdata);
      window_sum_sq_next = window_sum_sq_next - SQ_W'(old_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot    <= '0;
      fill_count    <= '0;
      window_sum    <= '0;
      window_sum_sq <= '0;
      last_filtered <= '0;
    end else if (commit) begin
      write_slot    <= (write_slot == SLOT_LAST) ? '0 : write_slot + 1'b1;
      if (!warm) fill_count <= fill_count + 1'b1;
      window_sum    <= window_sum_next;
      window_sum_sq <= window_sum_sq_next;
      last_filtered <= f_val;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      warmed_up   <= warm;
      peak_signal <= !take ? zsp_pkg::SIG_NONE :
                     above_reg ? zsp_pkg::SIG_POS : zsp_pkg::SIG_NEG;
    end
  end

  // ---------------- assertions ----------------
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == zsp_pkg::ST_DONE)
    else $error("result loaded outside write-back");

  a_no_peak_while_filling: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !warmed_up) |-> peak_signal == zsp_pkg::SIG_NONE)
    else $error("peak flagged before window filled");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_LAST)
    else $error("write slot out of range");

  a_empty_sums: assert property (@(posedge clk) disable iff (rst)
    (fill_count == '0) |-> (window_sum == '0 && window_sum_sq == '0))
    else $error("sums nonzero with empty window");

endmodule
